### hw/rtl/spg_pkg.sv
// ----------------------------------------------------------------------------
// spg_pkg: shared definitions for the sorted permutation generator
// Sizes, command and status codes, and the control bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package spg_pkg;

  localparam int MAX_CHARS = 8;
  localparam int IDX_W     = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
  localparam int CNT_W     = $clog2(MAX_CHARS + 1);

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_NEXT   = 2'd2;

  localparam logic [1:0] STS_CHAR     = 2'd0;
  localparam logic [1:0] STS_EXHAUST  = 2'd1;
  localparam logic [1:0] STS_TOO_LONG = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       clear;
    logic       insert;
    logic       emit_start;
    logic       emit;
    logic       put_status;
    logic [1:0] status_code;
    logic       find_pivot;
    logic       read_pivot;
    logic       find_succ;
    logic       swap;
    logic       rev_load;
    logic       rev_store;
  } spg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_zero;
    logic full;
    logic exhausted;
    logic emit_last;
    logic no_pivot;
    logic rev_done;
    logic out_free;
  } spg_stat_t;

endpackage

### hw/rtl/spg_ctrl.sv
// ----------------------------------------------------------------------------
// spg_ctrl: sequencer for the sorted permutation generator
// Decodes each request and steps the datapath through emission of the
// current arrangement and the successor search over the index order.
// ----------------------------------------------------------------------------
module spg_ctrl
  import spg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] command_i,
  input  spg_stat_t  stat_i,
  output spg_cmd_t   cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LONG = 4'd1;
  localparam logic [3:0] S_EXH  = 4'd2;
  localparam logic [3:0] S_EMIT = 4'd3;
  localparam logic [3:0] S_PIV  = 4'd4;
  localparam logic [3:0] S_PVR  = 4'd5;
  localparam logic [3:0] S_SUCC = 4'd6;
  localparam logic [3:0] S_SWAP = 4'd7;
  localparam logic [3:0] S_RVA  = 4'd8;
  localparam logic [3:0] S_RVB  = 4'd9;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (command_i)
            CMD_CLEAR: begin
              cmd_o.clear = 1'b1;
            end
            CMD_APPEND: begin
              if (stat_i.full) begin
                state_d = S_LONG;
              end else begin
                cmd_o.insert = 1'b1;
              end
            end
            CMD_NEXT: begin
              if (stat_i.cnt_zero || stat_i.exhausted) begin
                state_d = S_EXH;
              end else begin
                cmd_o.emit_start = 1'b1;
                state_d          = S_EMIT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_LONG: begin
        if (stat_i.out_free) begin
          cmd_o.put_status  = 1'b1;
          cmd_o.status_code = STS_TOO_LONG;
          state_d           = S_IDLE;
        end
      end
      S_EXH: begin
        if (stat_i.out_free) begin
          cmd_o.put_status  = 1'b1;
          cmd_o.status_code = STS_EXHAUST;
          state_d           = S_IDLE;
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.emit_last) begin
            state_d = S_PIV;
          end
        end
      end
      S_PIV: begin
        cmd_o.find_pivot = 1'b1;
        state_d = stat_i.no_pivot ? S_IDLE : S_PVR;
      end
      S_PVR: begin
        cmd_o.read_pivot = 1'b1;
        state_d          = S_SUCC;
      end
      S_SUCC: begin
        cmd_o.find_succ = 1'b1;
        state_d         = S_SWAP;
      end
      S_SWAP: begin
        cmd_o.swap = 1'b1;
        state_d    = S_RVA;
      end
      S_RVA: begin
        if (stat_i.rev_done) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.rev_load = 1'b1;
          state_d        = S_RVB;
        end
      end
      S_RVB: begin
        cmd_o.rev_store = 1'b1;
        state_d         = S_RVA;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hw/rtl/spg_dpath.sv
// ----------------------------------------------------------------------------
// spg_dpath: storage and result path for the sorted permutation generator
// Holds the sorted characters, the index order and the output register,
// and carries out one step of insertion, emission or successor search.
// ----------------------------------------------------------------------------
module spg_dpath
  import spg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] char_in_i,
  input  spg_cmd_t   cmd_i,
  output spg_stat_t  stat_o,
  output logic [7:0] char_out_o,
  output logic       last_char_o,
  output logic [1:0] status_o,
  output logic       out_valid_o,
  input  logic       out_ready_i
);

  logic [7:0]       chars_q [MAX_CHARS];
  logic [7:0]       chars_d [MAX_CHARS];
  logic [IDX_W-1:0] order_q [MAX_CHARS];
  logic [IDX_W-1:0] order_d [MAX_CHARS];
  logic [CNT_W-1:0] count_q, count_d;
  logic             exh_q, exh_d;
  logic [IDX_W-1:0] k_q, p_q, j_q, lo_q, hi_q, t_q, pv_q;
  logic             out_valid_q;
  logic [7:0]       out_char_q;
  logic             out_last_q;
  logic [1:0]       out_sts_q;

  logic [MAX_CHARS-1:0] gt;
  logic [IDX_W-1:0]     rd_addr, rd_data;
  logic [IDX_W-1:0]     piv_idx, succ_idx;
  logic                 piv_found;
  logic                 out_free;
  logic                 emit_last;

  assign out_free  = !out_valid_q || out_ready_i;
  assign emit_last = (CNT_W'(k_q) + CNT_W'(1)) == count_q;

  // One read port on the index order, steered by the current step.
  always_comb begin
    priority if (cmd_i.emit) begin
      rd_addr = k_q;
    end else if (cmd_i.read_pivot) begin
      rd_addr = p_q;
    end else if (cmd_i.swap) begin
      rd_addr = j_q;
    end else if (cmd_i.rev_load) begin
      rd_addr = lo_q;
    end else begin
      rd_addr = hi_q;
    end
  end
  assign rd_data = order_q[rd_addr];

  // The pivot is the last position that is smaller than its right neighbor.
  always_comb begin
    piv_idx   = '0;
    piv_found = 1'b0;
    for (int i = 1; i < MAX_CHARS; i++) begin
      if ((CNT_W'(i) < count_q) && (order_q[i-1] < order_q[i])) begin
        piv_idx   = IDX_W'(i - 1);
        piv_found = 1'b1;
      end
    end
  end

  // Rightmost entry larger than the pivot value.
  always_comb begin
    succ_idx = '0;
    for (int i = 0; i < MAX_CHARS; i++) begin
      if ((CNT_W'(i) < count_q) && (order_q[i] > pv_q)) begin
        succ_idx = IDX_W'(i);
      end
    end
  end

  // Insertion after any equal bytes: every larger held byte moves up one place.
  always_comb begin
    for (int i = 0; i < MAX_CHARS; i++) begin
      gt[i] = (CNT_W'(i) < count_q) && (chars_q[i] > char_in_i);
    end
    for (int i = 0; i < MAX_CHARS; i++) begin
      if (cmd_i.insert && ((CNT_W'(i) == count_q) || gt[i])) begin
        chars_d[i] = char_in_i;
      end else begin
        chars_d[i] = chars_q[i];
      end
    end
    for (int i = 1; i < MAX_CHARS; i++) begin
      if (cmd_i.insert && gt[i-1]) begin
        chars_d[i] = chars_q[i-1];
      end
    end
  end

  always_comb begin
    order_d = order_q;
    count_d = count_q;
    exh_d   = exh_q;
    if (cmd_i.clear || cmd_i.insert) begin
      for (int i = 0; i < MAX_CHARS; i++) begin
        order_d[i] = IDX_W'(i);
      end
      exh_d   = 1'b0;
      count_d = cmd_i.clear ? '0 : count_q + CNT_W'(1);
    end
    if (cmd_i.find_pivot && !piv_found) begin
      exh_d = 1'b1;
    end
    if (cmd_i.swap) begin
      order_d[p_q] = rd_data;
      order_d[j_q] = pv_q;
    end
    if (cmd_i.rev_store) begin
      order_d[lo_q] = rd_data;
      order_d[hi_q] = t_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CHARS; i++) begin
        order_q[i] <= IDX_W'(i);
      end
      count_q     <= '0;
      exh_q       <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      order_q <= order_d;
      count_q <= count_d;
      exh_q   <= exh_d;
      if (cmd_i.emit_start) begin
        k_q <= '0;
      end else if (cmd_i.emit) begin
        k_q <= k_q + IDX_W'(1);
      end
      if (cmd_i.emit || cmd_i.put_status) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chars_q <= chars_d;
    if (cmd_i.find_pivot) begin
      p_q <= piv_idx;
    end
    if (cmd_i.read_pivot) begin
      pv_q <= rd_data;
    end
    if (cmd_i.find_succ) begin
      j_q <= succ_idx;
    end
    if (cmd_i.swap) begin
      lo_q <= p_q + IDX_W'(1);
      hi_q <= IDX_W'(count_q - CNT_W'(1));
    end
    if (cmd_i.rev_load) begin
      t_q <= rd_data;
    end
    if (cmd_i.rev_store) begin
      lo_q <= lo_q + IDX_W'(1);
      hi_q <= hi_q - IDX_W'(1);
    end
    if (cmd_i.emit) begin
      out_char_q <= chars_q[rd_data];
      out_last_q <= emit_last;
      out_sts_q  <= STS_CHAR;
    end else if (cmd_i.put_status) begin
      out_char_q <= '0;
      out_last_q <= 1'b1;
      out_sts_q  <= cmd_i.status_code;
    end
  end

  assign stat_o.cnt_zero  = (count_q == '0);
  assign stat_o.full      = (count_q == CNT_W'(MAX_CHARS));
  assign stat_o.exhausted = exh_q;
  assign stat_o.emit_last = emit_last;
  assign stat_o.no_pivot  = !piv_found;
  assign stat_o.rev_done  = !(lo_q < hi_q);
  assign stat_o.out_free  = out_free;

  assign out_valid_o = out_valid_q;
  assign char_out_o  = out_char_q;
  assign last_char_o = out_last_q;
  assign status_o    = out_sts_q;

endmodule

### hw/rtl/sorted_permutation_generator.sv
// Clear and append finish as they are taken; a status result loads once the output register is free.
// A next request emits its n characters, one character per cycle while the output is free, then
// searches for the pivot (the last arrangement stops there), then reads the pivot, finds the
// successor, swaps and reverses the tail pair by pair, paced by the one index-order read port.
// One request at a time; a finished result waits in an output register meanwhile.
// Reset clears the count, the exhausted flag and sets the identity order; characters are not reset.
// ----------------------------------------------------------------------------
// sorted_permutation_generator: top level
// Keeps loaded characters sorted and emits their permutations in ascending
// lexicographic order, one character per result.
// ----------------------------------------------------------------------------
module sorted_permutation_generator
  import spg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] command_i,
  input  logic [7:0] char_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] char_out_o,
  output logic       last_char_o,
  output logic [1:0] status_o
);

  spg_cmd_t  cmd;
  spg_stat_t stat;

  spg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  spg_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_in_i   (char_in_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .char_out_o  (char_out_o),
    .last_char_o (last_char_o),
    .status_o    (status_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

  // A result is never loaded over one that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit || cmd.put_status) |-> stat.out_free)
    else $error("result loaded while output register is occupied");

  // Characters are emitted only from a non-empty store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !stat.cnt_zero)
    else $error("emission from an empty store");

  // A permutation request keeps the block busy on the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && command_i == CMD_NEXT) |=> !in_ready_o)
    else $error("next request did not occupy the sequencer");

  // Status results are always the final result of their run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STS_CHAR) |-> last_char_o)
    else $error("status result without last flag");

endmodule
